[hdl/hires_lores_dot_colorizer_macros.svh]
// Assertion macros for the hi-res / lo-res dot colorizer.
// Included by the top level; no other dependencies.
`ifndef HIRES_LORES_DOT_COLORIZER_MACROS_SVH
`define HIRES_LORES_DOT_COLORIZER_MACROS_SVH

`ifndef ASSERT_OFF
// Overlapping implication, checked at every clock edge out of reset
`define HLC_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);
// Non-overlapping implication, post checked in the next cycle
`define HLC_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define HLC_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg)
`define HLC_ASSERT_NXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

[hdl/hlc_pkg.sv]
// Shared types, constants and palette functions of the dot colorizer.
// No dependencies.
`default_nettype none
package hlc_pkg;

	localparam int unsigned DOTS_PER_BYTE = 7;
	localparam int unsigned DOT_W         = 3;
	localparam logic [DOT_W-1:0] LAST_DOT = 3'(DOTS_PER_BYTE - 1);

	localparam logic [23:0] BLACK_WORD = 24'h000000;
	localparam logic [23:0] WHITE_WORD = 24'hFFFFFF;
	localparam logic [23:0] MONO_GREEN = 24'h00FF00;

	// How the back end renders a byte
	typedef enum logic [1:0] {
		OP_HIRES = 2'd0,  // artifact color hi-res
		OP_MONO  = 2'd1,  // green monochrome hi-res
		OP_FLAT  = 2'd2   // seven dots of one precomputed color
	} op_t;

	// One classified byte, as queued between front and back
	typedef struct packed {
		op_t         op;
		logic [8:0]  bits9;       // left neighbour, dots 0..6, right neighbour
		logic        column_odd;
		logic        high_bit;
		logic [23:0] flat_color;
	} cmd_t;

	// Lo-res 16-entry palette
	function automatic logic [23:0] lores_color(input logic [3:0] idx);
		logic [23:0] c;
		unique case (idx)
			4'h0: c = 24'h000000;
			4'h1: c = 24'h7C0B93;
			4'h2: c = 24'hD3351F;
			4'h3: c = 24'hFF36BB;
			4'h4: c = 24'h0C7600;
			4'h5: c = 24'h7E7E7E;
			4'h6: c = 24'hE0A807;
			4'h7: c = 24'hFFAC9D;
			4'h8: c = 24'h004C62;
			4'h9: c = 24'h1D56F9;
			4'hA: c = 24'h7E7E7E;
			4'hB: c = 24'hEC81FF;
			4'hC: c = 24'h00C843;
			4'hD: c = 24'h16CDDC;
			4'hE: c = 24'h84F75D;
			4'hF: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

	// Artifact colors: code = {phase, bit 7}
	function automatic logic [23:0] artifact_color(input logic [1:0] code);
		logic [23:0] c;
		unique case (code)
			2'd0: c = 24'hFF36BB;  // purple
			2'd1: c = 24'hE0A807;  // blue
			2'd2: c = 24'h00C843;  // green
			2'd3: c = 24'h1D56F9;  // orange
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

[hdl/hlc_ifs.sv]
// Valid/ready channel interfaces: byte input and dot output.
// Depends on nothing.
`default_nettype none
interface hlc_byte_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic       left_dot;
	logic       right_dot;
	logic       column_odd;
	logic       lower_half;

	modport source (output valid, kind, data_byte, left_dot, right_dot, column_odd,
		lower_half, input ready);
	modport sink (input valid, kind, data_byte, left_dot, right_dot, column_odd,
		lower_half, output ready);
endinterface

interface hlc_dot_if;
	logic        valid;
	logic        ready;
	logic [23:0] dot_color;
	logic        last_dot;

	modport source (output valid, dot_color, last_dot, input ready);
	modport sink (input valid, dot_color, last_dot, output ready);
endinterface
`default_nettype wire

[hdl/hlc_front.sv]
// Front end: holds the monochrome register, accepts bytes and classifies them.
// Depends on hlc_pkg and hlc_byte_if.
`default_nettype none
module hlc_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	hlc_byte_if.sink         item,
	input  wire logic        q_full,
	output      logic        push,
	output      hlc_pkg::cmd_t cmd
);
	logic mono_q;
	logic [3:0] nibble;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mono_q <= 1'b0;
		end else if (cfg_we) begin
			mono_q <= cfg_wdata;
		end
	end

	assign item.ready = !q_full;
	assign push       = item.valid && !q_full;
	assign nibble     = item.lower_half ? item.data_byte[7:4] : item.data_byte[3:0];

	// Classify the byte
	always_comb begin
		cmd.bits9      = {item.right_dot, item.data_byte[6:0], item.left_dot};
		cmd.column_odd = item.column_odd;
		cmd.high_bit   = item.data_byte[7];
		cmd.flat_color = hlc_pkg::BLACK_WORD;
		if (item.kind) begin
			cmd.op = hlc_pkg::OP_FLAT;
			if (!mono_q) begin
				cmd.flat_color = hlc_pkg::lores_color(nibble);
			end
		end else if (mono_q) begin
			cmd.op = hlc_pkg::OP_MONO;
		end else begin
			cmd.op = hlc_pkg::OP_HIRES;
		end
	end
endmodule
`default_nettype wire

[hdl/hlc_queue.sv]
// Short command queue between front and back end.
// Depends on hlc_pkg.
`default_nettype none
module hlc_queue #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire hlc_pkg::cmd_t din,
	input  wire logic          pop,
	output hlc_pkg::cmd_t      dout,
	output      logic          full,
	output      logic          empty
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	hlc_pkg::cmd_t    mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= din;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

[hdl/hlc_back.sv]
// Back end: walks the seven dots of the queued byte into an output register.
// Depends on hlc_pkg and hlc_dot_if.
`default_nettype none
module hlc_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hlc_pkg::cmd_t cmd,
	input  wire logic          q_empty,
	output      logic          pop,
	output      logic          at_first_dot,
	hlc_dot_if.source          dots
);
	logic [hlc_pkg::DOT_W-1:0] dot_q;
	logic                      out_valid_q;
	logic [23:0]               color_q;
	logic                      last_q;
	logic                      load;
	logic                      is_last;
	logic [8:0]                win;
	logic                      lft, self_dot, rgt, phase;
	logic [23:0]               color;

	assign load         = !q_empty && (!out_valid_q || dots.ready);
	assign is_last      = (dot_q == hlc_pkg::LAST_DOT);
	assign pop          = load && is_last;
	assign at_first_dot = (dot_q == '0);

	// Neighbourhood of the current dot
	assign win      = cmd.bits9 >> dot_q;
	assign lft      = win[0];
	assign self_dot = win[1];
	assign rgt      = win[2];
	assign phase    = cmd.column_odd ^ dot_q[0];

	// Dot color
	always_comb begin
		color = hlc_pkg::BLACK_WORD;
		unique case (cmd.op)
			hlc_pkg::OP_HIRES: begin
				if (self_dot) begin
					color = (lft || rgt) ? hlc_pkg::WHITE_WORD
						: hlc_pkg::artifact_color({phase, cmd.high_bit});
				end else if (lft && rgt) begin
					color = hlc_pkg::artifact_color({!phase, cmd.high_bit});
				end
			end
			hlc_pkg::OP_MONO: begin
				color = self_dot ? hlc_pkg::MONO_GREEN : hlc_pkg::BLACK_WORD;
			end
			hlc_pkg::OP_FLAT: begin
				color = cmd.flat_color;
			end
			default: begin
				color = hlc_pkg::BLACK_WORD;
			end
		endcase
	end

	// Dot counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				dot_q       <= is_last ? '0 : dot_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (dots.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output word
	always_ff @(posedge clk) begin
		if (load) begin
			color_q <= color;
			last_q  <= is_last;
		end
	end

	assign dots.valid     = out_valid_q;
	assign dots.dot_color = color_q;
	assign dots.last_dot  = last_q;
endmodule
`default_nettype wire

[hdl/hires_lores_dot_colorizer.sv]
// Top level of the hi-res / lo-res dot colorizer.
// Depends on hlc_pkg, hlc_ifs, hlc_front, hlc_queue, hlc_back and the macros header.
//
// Usage:
//   item  : valid/ready byte channel (kind, data_byte, left_dot, right_dot,
//           column_odd, lower_half). A word is taken when valid and ready.
//   dots  : valid/ready dot channel; each byte gives seven words, left to right,
//           with last_dot set on the seventh.
//   cfg_we / cfg_wdata : writes the monochrome bit; write only while idle.
// Path: a taken byte is written into the queue, and its first dot is then registered in the output word.
// Throughput: one dot per cycle while dots.ready holds and the queue has a byte;
//   the back end's dot counter steps through the seven dots of each byte.
// The front end keeps taking bytes into a QUEUE_DEPTH-entry queue while the back
//   end is busy, so ready stays high until that queue is full.
// A stall on dots holds the current word and freezes the dot counter; the queue
//   then fills and item.ready drops.
// Reset clears the queue, the dot counter, the output valid and the
//   monochrome bit (color mode).
`default_nettype none
`include "hires_lores_dot_colorizer_macros.svh"
module hires_lores_dot_colorizer #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata,
	hlc_byte_if.sink  item,
	hlc_dot_if.source dots
);
	hlc_pkg::cmd_t in_cmd, head_cmd;
	logic          push, pop, q_full, q_empty, at_first_dot;

	// Accept and classify
	hlc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.q_full    (q_full),
		.push      (push),
		.cmd       (in_cmd)
	);

	// Decoupling queue
	hlc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (in_cmd),
		.pop    (pop),
		.dout   (head_cmd),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Render dots
	hlc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (head_cmd),
		.q_empty      (q_empty),
		.pop          (pop),
		.at_first_dot (at_first_dot),
		.dots         (dots)
	);

	// Checks
	`HLC_ASSERT_NXT(a_push_fills, clk, arst_n, item.valid && item.ready, !q_empty, "accepted byte not queued")
	`HLC_ASSERT_IMP(a_full_stalls, clk, arst_n, q_full, !item.ready, "ready high with queue full")
	`HLC_ASSERT_IMP(a_last_wraps, clk, arst_n, dots.valid && dots.last_dot, at_first_dot, "dot counter not wrapped after last dot")
endmodule
`default_nettype wire

[test/tb_hires_lores_dot_colorizer.sv]
// Self-checking testbench for hires_lores_dot_colorizer: directed bytes from a table, then
// random scan lines in color and monochrome mode, with dots predicted and compared in order.
// Depends on hlc_pkg, hlc_ifs and the RTL of the colorizer.
`timescale 1ns / 1ps
module tb_hires_lores_dot_colorizer;

	localparam logic KIND_HIRES = 1'b0;
	localparam logic KIND_LORES = 1'b1;
	localparam logic MODE_COLOR = 1'b0;
	localparam logic MODE_MONO  = 1'b1;

	localparam int DIR_COUNT    = 23;
	localparam int PHASE_COUNT  = 4;
	localparam int PRESS_AFTER  = 300;  // dots taken before the long hold-off
	localparam int PRESS_CYCLES = 120;
	localparam int DRAIN_LIMIT  = 20000;

	localparam logic [23:0] LORES_RGB [16] = '{
		24'h000000, 24'h7C0B93, 24'hD3351F, 24'hFF36BB,
		24'h0C7600, 24'h7E7E7E, 24'hE0A807, 24'hFFAC9D,
		24'h004C62, 24'h1D56F9, 24'h7E7E7E, 24'hEC81FF,
		24'h00C843, 24'h16CDDC, 24'h84F75D, 24'hFFFFFF
	};
	// purple, blue, green, orange; index = {phase, bit 7}
	localparam logic [23:0] ARTIFACT_RGB [4] = '{
		24'hFF36BB, 24'hE0A807, 24'h00C843, 24'h1D56F9
	};

	typedef struct {
		logic [23:0] color;
		logic        last;
	} dot_word_t;

	// One directed byte; typed rows carry one color for all seven dots
	typedef struct packed {
		logic        mode;
		logic        kind;
		logic [7:0]  data;
		logic        left;
		logic        right;
		logic        col;
		logic        lower;
		logic        typed;
		logic [23:0] flat;
	} dir_row_t;

	dir_row_t dir_rows [DIR_COUNT] = '{
		'{MODE_COLOR, KIND_HIRES, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_HIRES, 8'h7F, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, hlc_pkg::WHITE_WORD},
		'{MODE_COLOR, KIND_HIRES, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, hlc_pkg::WHITE_WORD},
		'{MODE_COLOR, KIND_HIRES, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_HIRES, 8'h81, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_HIRES, 8'h2A, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_HIRES, 8'hD5, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_HIRES, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_HIRES, 8'h40, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_HIRES, 8'hC1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_HIRES, 8'hAA, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_HIRES, 8'h55, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_LORES, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_LORES, 8'hF0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, hlc_pkg::WHITE_WORD},
		'{MODE_COLOR, KIND_LORES, 8'h9C, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_LORES, 8'h9C, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_LORES, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, hlc_pkg::WHITE_WORD},
		'{MODE_MONO,  KIND_HIRES, 8'hFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, hlc_pkg::MONO_GREEN},
		'{MODE_MONO,  KIND_HIRES, 8'h80, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, hlc_pkg::BLACK_WORD},
		'{MODE_MONO,  KIND_HIRES, 8'h55, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, hlc_pkg::BLACK_WORD},
		'{MODE_MONO,  KIND_LORES, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, hlc_pkg::BLACK_WORD},
		'{MODE_MONO,  KIND_LORES, 8'h0F, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, hlc_pkg::BLACK_WORD},
		'{MODE_COLOR, KIND_HIRES, 8'h7F, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, hlc_pkg::WHITE_WORD}
	};

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	hlc_byte_if byte_ch ();
	hlc_dot_if  dot_ch ();

	hires_lores_dot_colorizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (byte_ch),
		.dots      (dot_ch)
	);

	dot_word_t pending_dots [$];
	logic      mono_mode;
	int        fault_count = 0;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Color of dot i of one byte
	function automatic logic [23:0] dot_rgb(input logic mode, input logic kind,
		input logic [7:0] data, input logic left, input logic right, input logic col,
		input logic lower, input int unsigned i);
		logic [8:0] line9;
		logic       self_lit;
		logic       left_lit;
		logic       right_lit;
		logic       phase;
		logic [3:0] nib;
		line9 = {right, data[6:0], left};
		if (kind == KIND_LORES) begin
			if (mode == MODE_MONO)
				return hlc_pkg::BLACK_WORD;
			nib = lower ? data[7:4] : data[3:0];
			return LORES_RGB[nib];
		end
		if (mode == MODE_MONO)
			return data[i] ? hlc_pkg::MONO_GREEN : hlc_pkg::BLACK_WORD;
		self_lit  = line9[i + 1];
		left_lit  = line9[i];
		right_lit = line9[i + 2];
		if (self_lit) begin
			if (left_lit || right_lit)
				return hlc_pkg::WHITE_WORD;
			phase = col ^ i[0];
			return ARTIFACT_RGB[{phase, data[7]}];
		end
		// dark dot between two lit ones takes the opposite phase
		if (left_lit && right_lit) begin
			phase = ~(col ^ i[0]);
			return ARTIFACT_RGB[{phase, data[7]}];
		end
		return hlc_pkg::BLACK_WORD;
	endfunction

	// Mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one byte, wait for it to be taken, queue its seven dots
	task automatic offer_byte(input logic b_kind, input logic [7:0] b_data,
		input logic b_left, input logic b_right, input logic b_col, input logic b_lower,
		input logic typed, input logic [23:0] flat, input int unsigned gap);
		dot_word_t w;
		byte_ch.valid      <= 1'b1;
		byte_ch.kind       <= b_kind;
		byte_ch.data_byte  <= b_data;
		byte_ch.left_dot   <= b_left;
		byte_ch.right_dot  <= b_right;
		byte_ch.column_odd <= b_col;
		byte_ch.lower_half <= b_lower;
		@(posedge clk);
		while (!byte_ch.ready)
			@(posedge clk);
		for (int i = 0; i < hlc_pkg::DOTS_PER_BYTE; i++) begin
			w.color = typed ? flat :
				dot_rgb(mono_mode, b_kind, b_data, b_left, b_right, b_col, b_lower, i);
			w.last = (i == hlc_pkg::DOTS_PER_BYTE - 1);
			pending_dots.push_back(w);
		end
		if (gap > 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Write the mode bit once the block has drained
	task automatic write_mode(input logic mode);
		byte_ch.valid <= 1'b0;
		while (pending_dots.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		mono_mode = mode;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Dot checker
	always @(posedge clk) begin : dot_check
		dot_word_t want;
		if (arst_n && dot_ch.valid && dot_ch.ready) begin
			if (pending_dots.size() == 0) begin
				fault_count++;
				if (fault_count <= 10)
					$display("%0t: unexpected dot word color %h last %b", $realtime,
						dot_ch.dot_color, dot_ch.last_dot);
			end else begin
				want = pending_dots.pop_front();
				if (want.color !== dot_ch.dot_color || want.last !== dot_ch.last_dot) begin
					fault_count++;
					if (fault_count <= 10)
						$display("%0t: dot mismatch: expected color %h last %b, got %h last %b",
							$realtime, want.color, want.last, dot_ch.dot_color,
							dot_ch.last_dot);
				end
			end
		end
	end

	// Dot receiver: random stalls, calm stretches, one long hold-off
	initial begin : dot_receiver
		int unsigned hold;
		int unsigned mode_left;
		int unsigned taken;
		int unsigned r;
		logic        calm;
		logic        pressed;
		hold      = 0;
		mode_left = 0;
		taken     = 0;
		calm      = 1'b0;
		pressed   = 1'b0;
		dot_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (dot_ch.valid && dot_ch.ready)
				taken++;
			if (hold > 0) begin
				hold--;
				dot_ch.ready <= 1'b0;
			end else if (!pressed && taken >= PRESS_AFTER) begin
				// let the queue fill so the byte side stalls
				pressed = 1'b1;
				hold    = PRESS_CYCLES - 1;
				dot_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					calm      = ($urandom_range(0, 3) == 0);
					mode_left = $urandom_range(20, 80);
				end else begin
					mode_left--;
				end
				r = $urandom_range(0, 99);
				if (calm || r < 65) begin
					dot_ch.ready <= 1'b1;
				end else if (r < 95) begin
					dot_ch.ready <= 1'b0;
					hold = $urandom_range(0, 3);
				end else begin
					dot_ch.ready <= 1'b0;
					hold = $urandom_range(8, 30);
				end
			end
		end
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("hires_lores_dot_colorizer verification failed");
		$finish;
	end

	// Stimulus
	initial begin : byte_stimulus
		int          phase_len [PHASE_COUNT];
		logic        phase_mode [PHASE_COUNT];
		logic [7:0]  prev_b;
		logic [7:0]  cur_b;
		logic [7:0]  next_b;
		logic        col_par;
		logic        burst;
		int unsigned r;
		int unsigned gap;
		int unsigned drain;
		phase_len  = '{50, 25, 50, 30};
		phase_mode = '{MODE_COLOR, MODE_MONO, MODE_COLOR, MODE_MONO};
		mono_mode = MODE_COLOR;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= 1'b0;
		byte_ch.valid      <= 1'b0;
		byte_ch.kind       <= KIND_HIRES;
		byte_ch.data_byte  <= 8'h00;
		byte_ch.left_dot   <= 1'b0;
		byte_ch.right_dot  <= 1'b0;
		byte_ch.column_odd <= 1'b0;
		byte_ch.lower_half <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table; the first rows run on the reset mode
		for (int n = 0; n < DIR_COUNT; n++) begin
			if (dir_rows[n].mode != mono_mode)
				write_mode(dir_rows[n].mode);
			offer_byte(dir_rows[n].kind, dir_rows[n].data, dir_rows[n].left,
				dir_rows[n].right, dir_rows[n].col, dir_rows[n].lower,
				dir_rows[n].typed, dir_rows[n].flat, $urandom_range(0, 2));
		end

		// random scan lines: consistent neighbours and alternating columns,
		// with some lo-res bytes and some bytes of pure noise
		prev_b  = 8'h00;
		next_b  = 8'($urandom);
		col_par = 1'b0;
		burst   = 1'b0;
		for (int p = 0; p < PHASE_COUNT; p++) begin
			write_mode(phase_mode[p]);
			for (int n = 0; n < phase_len[p]; n++) begin
				if (n % 16 == 0)
					burst = ($urandom_range(0, 2) == 0);
				gap = burst ? 0 : pick_gap();
				r = $urandom_range(0, 99);
				if (r < 20) begin
					offer_byte(KIND_LORES, 8'($urandom), 1'($urandom), 1'($urandom),
						1'($urandom), 1'($urandom), 1'b0, hlc_pkg::BLACK_WORD, gap);
				end else if (r < 32) begin
					offer_byte(KIND_HIRES, 8'($urandom), 1'($urandom), 1'($urandom),
						1'($urandom), 1'($urandom), 1'b0, hlc_pkg::BLACK_WORD, gap);
				end else begin
					if ($urandom_range(0, 19) == 0) begin
						// new line at the left edge
						prev_b  = 8'h00;
						col_par = 1'b0;
					end
					cur_b  = next_b;
					next_b = ($urandom_range(0, 2) == 0) ? 8'($urandom & $urandom) : 8'($urandom);
					offer_byte(KIND_HIRES, cur_b, prev_b[6], next_b[0], col_par, 1'($urandom),
						1'b0, hlc_pkg::BLACK_WORD, gap);
					prev_b  = cur_b;
					col_par = ~col_par;
				end
			end
		end

		// drain
		byte_ch.valid <= 1'b0;
		drain = 0;
		while (pending_dots.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		if (pending_dots.size() != 0) begin
			fault_count++;
			$display("%0d dot words never arrived", pending_dots.size());
		end
		repeat (20) @(posedge clk);
		if (fault_count == 0)
			$display("hires_lores_dot_colorizer verification clean");
		else
			$display("hires_lores_dot_colorizer verification failed");
		$finish;
	end

endmodule
